// File: rtl/tol_pkg.sv
package tol_pkg;

  // Default table depth.
  localparam int CAPACITY_DEF = 64;

  // Field widths of a stored key: month, day, hour, minute, second.
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int KEY_W    = MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W;
  localparam int TAG_W    = 32;
  localparam int ENTRY_W  = KEY_W + TAG_W;

  // Range limits of the time fields.
  localparam logic signed [7:0] MONTH_MAX  = 8'sd12;
  localparam logic signed [7:0] DAY_MAX    = 8'sd31;
  localparam logic signed [7:0] HOUR_MAX   = 8'sd24;
  localparam logic signed [7:0] MINSEC_MAX = 8'sd60;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MONTH = 3'd1;
  localparam logic [2:0] ST_BAD_DAY   = 3'd2;
  localparam logic [2:0] ST_BAD_TIME  = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // Result kinds.
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  // Read address selection for the entry memory.
  localparam logic [1:0] RD_PTR = 2'd0;
  localparam logic [1:0] RD_DEC = 2'd1;
  localparam logic [1:0] RD_INC = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic signed [7:0] month_in;
    logic signed [7:0] day_in;
    logic signed [7:0] hour_in;
    logic signed [7:0] minute_in;
    logic signed [7:0] second_in;
    logic [TAG_W-1:0]  payload_tag_in;
  } rec_t;

  typedef struct packed {
    logic                result_kind;
    logic [2:0]          status_code;
    logic [MONTH_W-1:0]  month_out;
    logic [DAY_W-1:0]    day_out;
    logic [HOUR_W-1:0]   hour_out;
    logic [MINUTE_W-1:0] minute_out;
    logic [SECOND_W-1:0] second_out;
    logic [TAG_W-1:0]    payload_tag_out;
    logic                last_of_run;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       ptr_top;
    logic       ptr_zero;
    logic       ptr_dec;
    logic       ptr_inc;
    logic       rd_en;
    logic [1:0] rd_mode;
    logic       wr_shift;
    logic       wr_new_above;
    logic       wr_new_zero;
    logic       emit_status;
    logic       emit_entry;
    logic       count_inc;
    logic       count_clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       list_req;
    logic [2:0] code;
    logic [2:0] req_code;
    logic       count_zero;
    logic       ptr_zero;
    logic       ptr_last;
    logic       key_less;
    logic       out_free;
  } stat_t;

endpackage

// File: rtl/tol_in_if.sv
interface tol_in_if;
  logic                       valid;
  logic                       ready;
  logic signed [7:0]          month_in;
  logic signed [7:0]          day_in;
  logic signed [7:0]          hour_in;
  logic signed [7:0]          minute_in;
  logic signed [7:0]          second_in;
  logic [tol_pkg::TAG_W-1:0]  payload_tag_in;

  modport source (
    output valid, month_in, day_in, hour_in, minute_in, second_in, payload_tag_in,
    input  ready
  );
  modport sink (
    input  valid, month_in, day_in, hour_in, minute_in, second_in, payload_tag_in,
    output ready
  );
endinterface

// File: rtl/tol_out_if.sv
interface tol_out_if;
  logic                         valid;
  logic                         ready;
  logic                         result_kind;
  logic [2:0]                   status_code;
  logic [tol_pkg::MONTH_W-1:0]  month_out;
  logic [tol_pkg::DAY_W-1:0]    day_out;
  logic [tol_pkg::HOUR_W-1:0]   hour_out;
  logic [tol_pkg::MINUTE_W-1:0] minute_out;
  logic [tol_pkg::SECOND_W-1:0] second_out;
  logic [tol_pkg::TAG_W-1:0]    payload_tag_out;
  logic                         last_of_run;

  modport source (
    output valid, result_kind, status_code, month_out, day_out, hour_out,
           minute_out, second_out, payload_tag_out, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, result_kind, status_code, month_out, day_out, hour_out,
           minute_out, second_out, payload_tag_out, last_of_run,
    output ready
  );
endinterface

// File: rtl/tol_ram.sv
module tol_ram #(
  parameter int WIDTH = tol_pkg::ENTRY_W,
  parameter int DEPTH = tol_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/tol_dp.sv
module tol_dp #(
  parameter int CAPACITY = tol_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  tol_pkg::rec_t rec,
  input  logic          out_ready,
  output logic          out_valid,
  output tol_pkg::res_t res,
  input  tol_pkg::cmd_t cmd,
  output tol_pkg::stat_t stat
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]            count;
  logic [CW-1:0]            count_m1;
  logic [IW-1:0]            ptr;
  logic [IW-1:0]            ptr_p1;
  logic [IW-1:0]            rd_addr;
  logic [IW-1:0]            wr_addr;
  logic [tol_pkg::KEY_W-1:0] req_key;
  logic [tol_pkg::TAG_W-1:0] req_tag;
  logic [2:0]               req_code;
  logic [tol_pkg::KEY_W-1:0] in_key;
  tol_pkg::entry_t          rd_data;
  tol_pkg::entry_t          wr_data;
  logic                     wr_en;
  logic                     month_ok;
  logic                     day_ok;
  logic                     time_ok;
  logic                     full;
  logic                     out_free;

  assign count_m1 = count - 1'b1;
  assign ptr_p1   = ptr + 1'b1;
  assign full     = (count == CW'(CAPACITY));
  assign out_free = !out_valid || out_ready;

  // Field checks on the incoming record.
  assign month_ok = (rec.month_in >= 8'sd1) && (rec.month_in <= tol_pkg::MONTH_MAX);
  assign day_ok   = (rec.day_in >= 8'sd1) && (rec.day_in <= tol_pkg::DAY_MAX);
  assign time_ok  = (rec.hour_in >= 8'sd0) && (rec.hour_in <= tol_pkg::HOUR_MAX) &&
                    (rec.minute_in >= 8'sd0) && (rec.minute_in <= tol_pkg::MINSEC_MAX) &&
                    (rec.second_in >= 8'sd0) && (rec.second_in <= tol_pkg::MINSEC_MAX);

  assign in_key = {rec.month_in[tol_pkg::MONTH_W-1:0], rec.day_in[tol_pkg::DAY_W-1:0],
                   rec.hour_in[tol_pkg::HOUR_W-1:0], rec.minute_in[tol_pkg::MINUTE_W-1:0],
                   rec.second_in[tol_pkg::SECOND_W-1:0]};

  always_comb begin
    stat.list_req = (rec.month_in == 8'sd0) || (rec.day_in == 8'sd0);
    if (full) begin
      stat.code = tol_pkg::ST_FULL;
    end else if (!month_ok) begin
      stat.code = tol_pkg::ST_BAD_MONTH;
    end else if (!day_ok) begin
      stat.code = tol_pkg::ST_BAD_DAY;
    end else if (!time_ok) begin
      stat.code = tol_pkg::ST_BAD_TIME;
    end else begin
      stat.code = tol_pkg::ST_OK;
    end
    stat.req_code   = req_code;
    stat.count_zero = (count == '0);
    stat.ptr_zero   = (ptr == '0);
    stat.ptr_last   = (ptr == count_m1[IW-1:0]);
    stat.key_less   = (req_key < rd_data.key);
    stat.out_free   = out_free;
  end

  always_comb begin
    case (cmd.rd_mode)
      tol_pkg::RD_DEC: rd_addr = ptr - 1'b1;
      tol_pkg::RD_INC: rd_addr = ptr_p1;
      default:         rd_addr = ptr;
    endcase
  end

  assign wr_en   = cmd.wr_shift || cmd.wr_new_above || cmd.wr_new_zero;
  assign wr_addr = cmd.wr_new_zero ? '0 : ptr_p1;
  assign wr_data = cmd.wr_shift ? rd_data : tol_pkg::entry_t'{key: req_key, tag: req_tag};

  tol_ram #(
    .WIDTH (tol_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_key  <= in_key;
      req_tag  <= rec.payload_tag_in;
      req_code <= stat.code;
    end
    if (cmd.ptr_top) begin
      ptr <= count_m1[IW-1:0];
    end else if (cmd.ptr_zero) begin
      ptr <= '0;
    end else if (cmd.ptr_dec) begin
      ptr <= ptr - 1'b1;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr_p1;
    end
    if (out_free && cmd.emit_status) begin
      res.result_kind     <= tol_pkg::KIND_STATUS;
      res.status_code     <= req_code;
      res.month_out       <= '0;
      res.day_out         <= '0;
      res.hour_out        <= '0;
      res.minute_out      <= '0;
      res.second_out      <= '0;
      res.payload_tag_out <= '0;
      res.last_of_run     <= 1'b1;
    end else if (out_free && cmd.emit_entry) begin
      res.result_kind     <= tol_pkg::KIND_ENTRY;
      res.status_code     <= tol_pkg::ST_OK;
      {res.month_out, res.day_out, res.hour_out, res.minute_out, res.second_out}
                          <= rd_data.key;
      res.payload_tag_out <= rd_data.tag;
      res.last_of_run     <= stat.ptr_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.count_clear) begin
        count <= '0;
      end else if (cmd.count_inc) begin
        count <= count + 1'b1;
      end
      if (out_free && (cmd.emit_status || cmd.emit_entry)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/tol_ctrl.sv
module tol_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tol_pkg::stat_t stat,
  output tol_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_LST_RD   = 3'd1;
  localparam logic [2:0] S_LST_OUT  = 3'd2;
  localparam logic [2:0] S_INS_RD   = 3'd3;
  localparam logic [2:0] S_INS_SCAN = 3'd4;
  localparam logic [2:0] S_INS_ZERO = 3'd5;
  localparam logic [2:0] S_RESP     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_mode = tol_pkg::RD_PTR;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.list_req) begin
            if (stat.count_zero) begin
              cmd.count_clear = 1'b1;
            end else begin
              cmd.ptr_zero = 1'b1;
              state_next   = S_LST_RD;
            end
          end else if (stat.code != tol_pkg::ST_OK) begin
            state_next = S_RESP;
          end else if (stat.count_zero) begin
            state_next = S_INS_ZERO;
          end else begin
            cmd.ptr_top = 1'b1;
            state_next  = S_INS_RD;
          end
        end
      end
      S_LST_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LST_OUT;
      end
      S_LST_OUT: begin
        if (stat.out_free) begin
          cmd.emit_entry = 1'b1;
          if (stat.ptr_last) begin
            cmd.count_clear = 1'b1;
            state_next      = S_IDLE;
          end else begin
            cmd.ptr_inc = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_mode = tol_pkg::RD_INC;
          end
        end
      end
      S_INS_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_INS_SCAN;
      end
      S_INS_SCAN: begin
        if (stat.key_less) begin
          cmd.wr_shift = 1'b1;
          if (stat.ptr_zero) begin
            state_next = S_INS_ZERO;
          end else begin
            cmd.ptr_dec = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_mode = tol_pkg::RD_DEC;
          end
        end else begin
          cmd.wr_new_above = 1'b1;
          cmd.count_inc    = 1'b1;
          state_next       = S_RESP;
        end
      end
      S_INS_ZERO: begin
        cmd.wr_new_zero = 1'b1;
        cmd.count_inc   = 1'b1;
        state_next      = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.emit_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/time_ordered_insert_list.sv
// Time-ordered record list. Records arrive on the rec channel, each with a
// month, day, hour, minute, second and a 32-bit payload tag, and are kept in
// a single-port-write, registered-read memory in ascending time order.
// Results leave on the result channel; both channels move one request when
// valid and ready are high together.
// A valid record yields one status result (accepted) after it is placed
// behind every entry with an equal key. Placement scans from the top entry
// down, moving each later entry up one slot, one entry per cycle through the
// memory's read-compare-write loop. From acceptance until the next request
// can be taken, an insert steps through S_INS_RD, one S_INS_SCAN step per
// stored entry later than the new record, the new entry's write and S_RESP
// (only the write and S_RESP on an empty table). A bad record or an insert
// into a full table yields one error status and leaves the table untouched.
// A record with month or day zero lists the table: each stored entry comes
// out in order, one per cycle while the receiver keeps up, the final one with
// last_of_run set, and the table is then empty. An empty table gives no
// results at all.
// One request is worked at a time; rec.ready is high only between requests.
// The result sits in an output register, so a stalled receiver only holds the
// controller where the next result is due. Reset empties the table at once.
module time_ordered_insert_list #(
  parameter int CAPACITY = tol_pkg::CAPACITY_DEF
) (
  input logic      clk,
  input logic      rst,
  tol_in_if.sink   rec,
  tol_out_if.source result
);

  tol_pkg::rec_t  rec_data;
  tol_pkg::res_t  res_data;
  tol_pkg::cmd_t  cmd;
  tol_pkg::stat_t stat;
  logic           in_ready;
  logic           out_valid;

  // Gather the request fields into one word for the datapath.
  assign rec_data.month_in       = rec.month_in;
  assign rec_data.day_in         = rec.day_in;
  assign rec_data.hour_in        = rec.hour_in;
  assign rec_data.minute_in      = rec.minute_in;
  assign rec_data.second_in      = rec.second_in;
  assign rec_data.payload_tag_in = rec.payload_tag_in;
  assign rec.ready               = in_ready;

  // The controller sequences the scan, shift and listing steps.
  tol_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rec.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the table, the entry count and the output register.
  tol_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .rec       (rec_data),
    .out_ready (result.ready),
    .out_valid (out_valid),
    .res       (res_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  assign result.valid           = out_valid;
  assign result.result_kind     = res_data.result_kind;
  assign result.status_code     = res_data.status_code;
  assign result.month_out       = res_data.month_out;
  assign result.day_out         = res_data.day_out;
  assign result.hour_out        = res_data.hour_out;
  assign result.minute_out      = res_data.minute_out;
  assign result.second_out      = res_data.second_out;
  assign result.payload_tag_out = res_data.payload_tag_out;
  assign result.last_of_run     = res_data.last_of_run;

endmodule

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Table depth of the block under test, and the margin of quiet cycles that
  // must pass at the end so that a stray result would still be caught.
  localparam int DEPTH       = tol_pkg::CAPACITY_DEF;
  localparam int DRAIN_WAIT  = 2 * DEPTH + 20;
  // Least number of requests offered in total, directed rows included.
  localparam int ITEM_TARGET = 310;
  // Length of the one long receiver hold-off, and the backlog that starts it.
  localparam int HOLD_CYCLES = 500;
  localparam int HOLD_LEVEL  = 40;
  // Share of cycles, in percent, in which each side idles.
  localparam int IDLE_PCT    = 17;

  // How a directed row is judged: by the predictor, by one typed status
  // result, or by the absence of any result.
  typedef enum {ROW_PREDICT, ROW_STATUS, ROW_SILENT} row_check_t;

  typedef struct {
    row_check_t  kind;
    logic [2:0]  code;
    byte         month;
    byte         day;
    byte         hour;
    byte         minute;
    byte         second;
    int unsigned tag;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 25;

  // Directed stimulus. Status rows carry the code that the request must get;
  // the list requests that return entries are left to the predictor.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // A list request right after reset finds an empty table: no results.
    '{ROW_SILENT, tol_pkg::ST_OK,         0,  5,  10,  10,  10, 32'h0000_0001},
    // Month out of range, low and high; month is checked before day and time.
    '{ROW_STATUS, tol_pkg::ST_BAD_MONTH, 13,  1,   0,   0,   0, 32'h0000_0000},
    '{ROW_STATUS, tol_pkg::ST_BAD_MONTH, -9, 31,  24,  60,  60, 32'hFFFF_FFFF},
    '{ROW_STATUS, tol_pkg::ST_BAD_MONTH, 99, 40,  99,  99,  99, 32'h0000_0000},
    // Day out of range; day is checked before the time fields.
    '{ROW_STATUS, tol_pkg::ST_BAD_DAY,   12, 32,   0,   0,   0, 32'h0000_0000},
    '{ROW_STATUS, tol_pkg::ST_BAD_DAY,    1, -1,   0,   0,   0, 32'h0000_0000},
    '{ROW_STATUS, tol_pkg::ST_BAD_DAY,    1, 99,  -9,  61,  99, 32'h0000_0000},
    // Any single time field out of range rejects the record.
    '{ROW_STATUS, tol_pkg::ST_BAD_TIME,   1,  1,  25,   0,   0, 32'h0000_0000},
    '{ROW_STATUS, tol_pkg::ST_BAD_TIME,   1,  1,  -1,   0,   0, 32'h0000_0000},
    '{ROW_STATUS, tol_pkg::ST_BAD_TIME,   1,  1,   0,  61,   0, 32'h0000_0000},
    '{ROW_STATUS, tol_pkg::ST_BAD_TIME,   1,  1,   0,  -9,   0, 32'h0000_0000},
    '{ROW_STATUS, tol_pkg::ST_BAD_TIME,   1,  1,   0,   0,  61, 32'h0000_0000},
    '{ROW_STATUS, tol_pkg::ST_BAD_TIME,   1,  1,   0,   0,  -1, 32'h0000_0000},
    // Inserts at the extremes of every field.
    '{ROW_STATUS, tol_pkg::ST_OK,        12, 31,  24,  60,  60, 32'hFFFF_FFFF},
    '{ROW_STATUS, tol_pkg::ST_OK,         1,  1,   0,   0,   0, 32'h0000_0000},
    // Two equal keys: the second one must land after the first.
    '{ROW_STATUS, tol_pkg::ST_OK,         6, 15,  12,  30,  30, 32'hA5A5_A5A5},
    '{ROW_STATUS, tol_pkg::ST_OK,         6, 15,  12,  30,  30, 32'h5A5A_5A5A},
    // Lower fields only decide when every higher field is equal.
    '{ROW_STATUS, tol_pkg::ST_OK,         6, 15,  12,  30,  29, 32'h0000_0002},
    '{ROW_STATUS, tol_pkg::ST_OK,         6, 15,  12,  29,  59, 32'h0000_0003},
    '{ROW_STATUS, tol_pkg::ST_OK,         6, 14,  23,  59,  59, 32'h0000_0004},
    '{ROW_STATUS, tol_pkg::ST_OK,         7,  1,   0,   0,   0, 32'h0000_0005},
    // List everything, then list again on the now empty table.
    '{ROW_PREDICT, tol_pkg::ST_OK,        0,  0,   0,   0,   0, 32'h0000_0000},
    '{ROW_SILENT,  tol_pkg::ST_OK,       99,  0,  -5,  70, 127, 32'hDEAD_BEEF},
    // A single entry listed by a request with a valid month and day zero.
    '{ROW_STATUS, tol_pkg::ST_OK,         3,  9,   8,   7,   6, 32'h1234_5678},
    '{ROW_PREDICT, tol_pkg::ST_OK,        3,  0,  40,  -3,   9, 32'h0000_0000}
  };

  logic clk;
  logic rst;

  tol_in_if  rec_if();
  tol_out_if res_if();

  time_ordered_insert_list #(
    .CAPACITY(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .rec(rec_if),
    .result(res_if)
  );

  // Predictor state: the stored records in time order, oldest key first.
  tol_pkg::entry_t sorted_entries[$];
  // Results still owed by the block, oldest first.
  tol_pkg::res_t   owed_results[$];
  // Results of the request being predicted right now.
  tol_pkg::res_t   fresh_results[$];
  // How each offered request is to be judged, in the order of acceptance.
  row_check_t      pending_kinds[$];
  logic [2:0]      pending_codes[$];

  int unsigned error_count;
  int unsigned offered_count;
  // While set, neither side idles.
  bit          steady;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Generous upper bound on the run: far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic tol_pkg::res_t status_result(input logic [2:0] code);
    tol_pkg::res_t r;
    r = '0;
    r.result_kind = tol_pkg::KIND_STATUS;
    r.status_code = code;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  // Works out what one accepted request must produce, and updates the
  // predicted table. The results go to fresh_results.
  function automatic void predict_request(input tol_pkg::rec_t req);
    int                        m, d, h, mi, s, n, pos;
    logic [tol_pkg::KEY_W-1:0] key;
    tol_pkg::entry_t           e;
    tol_pkg::res_t             r;
    m  = $signed(req.month_in);
    d  = $signed(req.day_in);
    h  = $signed(req.hour_in);
    mi = $signed(req.minute_in);
    s  = $signed(req.second_in);
    n  = sorted_entries.size();
    fresh_results.delete();
    // A zero month or day lists the table whatever else the request holds.
    if (m == 0 || d == 0) begin
      foreach (sorted_entries[i]) begin
        r = '0;
        r.result_kind     = tol_pkg::KIND_ENTRY;
        r.status_code     = tol_pkg::ST_OK;
        {r.month_out, r.day_out, r.hour_out, r.minute_out, r.second_out} =
          sorted_entries[i].key;
        r.payload_tag_out = sorted_entries[i].tag;
        r.last_of_run     = (i == n - 1);
        fresh_results.push_back(r);
      end
      sorted_entries.delete();
      return;
    end
    // A full table is reported before any field is looked at.
    if (n >= DEPTH) begin
      fresh_results.push_back(status_result(tol_pkg::ST_FULL));
      return;
    end
    if (m < 1 || m > tol_pkg::MONTH_MAX) begin
      fresh_results.push_back(status_result(tol_pkg::ST_BAD_MONTH));
      return;
    end
    if (d < 1 || d > tol_pkg::DAY_MAX) begin
      fresh_results.push_back(status_result(tol_pkg::ST_BAD_DAY));
      return;
    end
    if (h < 0 || h > tol_pkg::HOUR_MAX || mi < 0 || mi > tol_pkg::MINSEC_MAX ||
        s < 0 || s > tol_pkg::MINSEC_MAX) begin
      fresh_results.push_back(status_result(tol_pkg::ST_BAD_TIME));
      return;
    end
    key = {m[tol_pkg::MONTH_W-1:0], d[tol_pkg::DAY_W-1:0], h[tol_pkg::HOUR_W-1:0],
           mi[tol_pkg::MINUTE_W-1:0], s[tol_pkg::SECOND_W-1:0]};
    // The new record goes after every entry whose key is not larger.
    pos = n;
    for (int i = 0; i < n; i++) begin
      if (key < sorted_entries[i].key) begin
        pos = i;
        break;
      end
    end
    e.key = key;
    e.tag = req.payload_tag_in;
    sorted_entries.insert(pos, e);
    fresh_results.push_back(status_result(tol_pkg::ST_OK));
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Both channels are observed at the rising edge, before any of the
  // nonblocking updates of that edge take effect. An accepted request is
  // predicted first, then a delivered result is checked against the oldest
  // expectation.
  always @(posedge clk) begin : observe
    tol_pkg::rec_t req;
    tol_pkg::res_t got;
    tol_pkg::res_t want;
    row_check_t    kind;
    logic [2:0]    code;
    if (!rst && rec_if.valid && rec_if.ready) begin
      req.month_in       = rec_if.month_in;
      req.day_in         = rec_if.day_in;
      req.hour_in        = rec_if.hour_in;
      req.minute_in      = rec_if.minute_in;
      req.second_in      = rec_if.second_in;
      req.payload_tag_in = rec_if.payload_tag_in;
      kind = ROW_PREDICT;
      code = tol_pkg::ST_OK;
      if (pending_kinds.size() != 0) begin
        kind = pending_kinds.pop_front();
        code = pending_codes.pop_front();
      end
      predict_request(req);
      // Typed rows replace the predicted results, but the table still
      // follows the predictor so that later rows see the right contents.
      case (kind)
        ROW_STATUS: owed_results.push_back(status_result(code));
        ROW_SILENT: ;
        default: begin
          foreach (fresh_results[i]) owed_results.push_back(fresh_results[i]);
        end
      endcase
    end
    if (!rst && res_if.valid && res_if.ready) begin
      got.result_kind     = res_if.result_kind;
      got.status_code     = res_if.status_code;
      got.month_out       = res_if.month_out;
      got.day_out         = res_if.day_out;
      got.hour_out        = res_if.hour_out;
      got.minute_out      = res_if.minute_out;
      got.second_out      = res_if.second_out;
      got.payload_tag_out = res_if.payload_tag_out;
      got.last_of_run     = res_if.last_of_run;
      if (owed_results.size() == 0) begin
        $error("result with no request waiting for it: kind %0d status %0d",
               got.result_kind, got.status_code);
        error_count++;
      end else begin
        want = owed_results.pop_front();
        compare_field("result_kind", want.result_kind, got.result_kind);
        compare_field("status_code", want.status_code, got.status_code);
        compare_field("month_out", want.month_out, got.month_out);
        compare_field("day_out", want.day_out, got.day_out);
        compare_field("hour_out", want.hour_out, got.hour_out);
        compare_field("minute_out", want.minute_out, got.minute_out);
        compare_field("second_out", want.second_out, got.second_out);
        compare_field("payload_tag_out", want.payload_tag_out,
                      got.payload_tag_out);
        compare_field("last_of_run", want.last_of_run, got.last_of_run);
      end
    end
  end

  // Receiver. Ready drops in about one cycle out of six, except during the
  // steady stretch. Once, when a long list is owed, the receiver holds off
  // for a long count of cycles while the sender keeps offering requests, so
  // the block has to stall its input.
  initial begin : receiver
    bit held;
    held = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && !rst && owed_results.size() > HOLD_LEVEL) begin
        held = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic byte pick(input int lo, input int hi);
    return byte'(lo + int'($urandom_range(hi - lo)));
  endfunction

  // A value outside the valid range of a field whose range is lo..hi.
  function automatic byte out_of_range(input int lo, input int hi);
    case ($urandom_range(2))
      0:       return pick(-9, lo - 1);
      1:       return pick(hi + 1, 99);
      default: return $urandom_range(1) ? pick(100, 127) : pick(-128, -10);
    endcase
  endfunction

  // A well-formed record. Some keys come from a narrow pool so that equal
  // and nearly equal keys meet in the table.
  function automatic tol_pkg::rec_t good_record();
    tol_pkg::rec_t r;
    if ($urandom_range(99) < 30) begin
      r.month_in  = pick(1, 2);
      r.day_in    = pick(1, 2);
      r.hour_in   = pick(0, 1);
      r.minute_in = pick(0, 1);
      r.second_in = pick(0, 1);
    end else begin
      r.month_in  = pick(1, tol_pkg::MONTH_MAX);
      r.day_in    = pick(1, tol_pkg::DAY_MAX);
      r.hour_in   = pick(0, tol_pkg::HOUR_MAX);
      r.minute_in = pick(0, tol_pkg::MINSEC_MAX);
      r.second_in = pick(0, tol_pkg::MINSEC_MAX);
    end
    r.payload_tag_in = $urandom;
    return r;
  endfunction

  // A well-formed record with one field pushed out of its range.
  function automatic tol_pkg::rec_t broken_record();
    tol_pkg::rec_t r;
    r = good_record();
    case ($urandom_range(4))
      0:       r.month_in  = out_of_range(1, tol_pkg::MONTH_MAX);
      1:       r.day_in    = out_of_range(1, tol_pkg::DAY_MAX);
      2:       r.hour_in   = out_of_range(0, tol_pkg::HOUR_MAX);
      3:       r.minute_in = out_of_range(0, tol_pkg::MINSEC_MAX);
      default: r.second_in = out_of_range(0, tol_pkg::MINSEC_MAX);
    endcase
    return r;
  endfunction

  // Any bit pattern at all, mostly within the nominal field span.
  function automatic tol_pkg::rec_t noise_record();
    tol_pkg::rec_t r;
    bit            wide;
    wide = ($urandom_range(3) == 0);
    r.month_in       = wide ? byte'($urandom_range(255)) : pick(-9, 99);
    r.day_in         = wide ? byte'($urandom_range(255)) : pick(-9, 99);
    r.hour_in        = wide ? byte'($urandom_range(255)) : pick(-9, 99);
    r.minute_in      = wide ? byte'($urandom_range(255)) : pick(-9, 99);
    r.second_in      = wide ? byte'($urandom_range(255)) : pick(-9, 99);
    r.payload_tag_in = $urandom;
    return r;
  endfunction

  // A list request: month or day zero, the rest arbitrary.
  function automatic tol_pkg::rec_t list_record();
    tol_pkg::rec_t r;
    r = noise_record();
    case ($urandom_range(2))
      0:       r.month_in = 8'sd0;
      1:       r.day_in   = 8'sd0;
      default: begin
        r.month_in = 8'sd0;
        r.day_in   = 8'sd0;
      end
    endcase
    return r;
  endfunction

  // Offers one request, with random idle cycles ahead of it, and returns at
  // the edge that accepts it. Valid stays high from one request to the next
  // when no idle cycle falls between them.
  task automatic offer(input tol_pkg::rec_t r, input row_check_t kind,
                       input logic [2:0] code);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      rec_if.valid <= 1'b0;
      @(posedge clk);
    end
    pending_kinds.push_back(kind);
    pending_codes.push_back(code);
    rec_if.valid          <= 1'b1;
    rec_if.month_in       <= r.month_in;
    rec_if.day_in         <= r.day_in;
    rec_if.hour_in        <= r.hour_in;
    rec_if.minute_in      <= r.minute_in;
    rec_if.second_in      <= r.second_in;
    rec_if.payload_tag_in <= r.payload_tag_in;
    offered_count++;
    @(posedge clk);
    while (!rec_if.ready) @(posedge clk);
  endtask

  // Sender and overall sequence.
  initial begin : sender
    tol_pkg::rec_t r;
    int            burst;
    int            fill;
    int            roll;
    error_count   = 0;
    offered_count = 0;
    steady        = 1'b0;
    rec_if.valid          <= 1'b0;
    rec_if.month_in       <= '0;
    rec_if.day_in         <= '0;
    rec_if.hour_in        <= '0;
    rec_if.minute_in      <= '0;
    rec_if.second_in      <= '0;
    rec_if.payload_tag_in <= '0;
    @(posedge clk);
    while (rst) @(posedge clk);

    // Directed part: walk the table of rows.
    foreach (directed_rows[i]) begin
      r.month_in       = directed_rows[i].month;
      r.day_in         = directed_rows[i].day;
      r.hour_in        = directed_rows[i].hour;
      r.minute_in      = directed_rows[i].minute;
      r.second_in      = directed_rows[i].second;
      r.payload_tag_in = directed_rows[i].tag;
      offer(r, directed_rows[i].kind, directed_rows[i].code);
    end

    // Random part, in bursts: a handful of records, mostly well formed,
    // then a list request that drains the table. One burst fills the table
    // past its capacity so that full is reported, bad records included,
    // and the longest possible list comes out against a stalled receiver.
    burst = 0;
    while (offered_count < ITEM_TARGET) begin
      steady = (burst >= 10 && burst <= 14);
      if (burst == 6) begin
        for (fill = 0; fill < DEPTH + 2; fill++)
          offer(good_record(), ROW_PREDICT, tol_pkg::ST_OK);
        for (fill = 0; fill < 3; fill++)
          offer(broken_record(), ROW_PREDICT, tol_pkg::ST_OK);
      end else begin
        for (fill = $urandom_range(12); fill > 0; fill--) begin
          roll = $urandom_range(99);
          if (roll < 70)
            r = good_record();
          else if (roll < 85)
            r = broken_record();
          else
            r = noise_record();
          offer(r, ROW_PREDICT, tol_pkg::ST_OK);
        end
      end
      offer(list_record(), ROW_PREDICT, tol_pkg::ST_OK);
      burst++;
    end
    steady = 1'b0;
    rec_if.valid <= 1'b0;

    // Let the edge of the last acceptance be observed, wait for every owed
    // result, then give a stray result time to show up.
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && owed_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: sim.f
rtl/tol_pkg.sv
rtl/tol_in_if.sv
rtl/tol_out_if.sv
rtl/tol_ram.sv
rtl/tol_dp.sv
rtl/tol_ctrl.sv
rtl/time_ordered_insert_list.sv
dv/testbench.sv
